// File: rtl/refcounted_inode_handle_table_macros.svh
// Assertion macros used by the handle table checker.
`ifndef REFCOUNTED_INODE_HANDLE_TABLE_MACROS_SVH
`define REFCOUNTED_INODE_HANDLE_TABLE_MACROS_SVH

// Property checked on the rising clock edge, off while reset is held.
`define RCIT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Property checked on every rising clock edge, reset included.
`define RCIT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: rtl/rcit_pkg.sv
// Types, codes and constants of the reference-counted inode handle table.
package rcit_pkg;

  localparam int SlotsDef       = 64;
  localparam int IpbDef         = 64;
  localparam int DiskBlockBytes = 4096;

  localparam int IdxW  = 8;   // holds any slot number up to 256 slots
  localparam int InoW  = 15;
  localparam int CntW  = 16;
  localparam int BlkW  = 16;
  localparam int OffW  = 12;
  localparam int SlotW = 6;
  localparam int OpW   = 2;
  localparam int StsW  = 3;

  localparam logic [BlkW-1:0] FirstBlockRst = 16'd3;
  localparam logic [CntW-1:0] CountMax      = '1;

  typedef enum logic [OpW-1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [StsW-1:0] {
    STS_HIT       = 3'd0,
    STS_MISS      = 3'd1,
    STS_NOFREE    = 3'd2,
    STS_IGNORED   = 3'd3,
    STS_RELEASED  = 3'd4,
    STS_WRITEBACK = 3'd5,
    STS_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_RESP
  } fsm_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INC,
    CMD_DEC,
    CMD_CLAIM,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [InoW-1:0]  inode_number;
    logic [SlotW-1:0] slot;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot_index;
    logic [CntW-1:0]  references;
    logic [InoW-1:0]  inode_of_slot;
    logic [BlkW-1:0]  disk_block;
    logic [OffW-1:0]  byte_offset;
  } out_t;

  // Search record passed from cell to cell
  typedef struct packed {
    logic             vld;
    logic [InoW-1:0]  inode;
    logic [SlotW-1:0] slot;
    logic             hit_fnd;
    logic [IdxW-1:0]  hit_idx;
    logic [CntW-1:0]  hit_cnt;
    logic             free_fnd;
    logic [IdxW-1:0]  free_idx;
    logic [CntW-1:0]  put_cnt;
    logic [InoW-1:0]  put_ino;
  } scan_t;

  // Update broadcast to all cells
  typedef struct packed {
    cmd_e            kind;
    logic [IdxW-1:0] idx;
    logic [InoW-1:0] inode;
  } cmd_t;

endpackage

// File: rtl/rcit_cell.sv
// One table slot: inode number, reference count and one stage of the search chain.
module rcit_cell #(
  parameter int IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rcit_pkg::cmd_t  cmd_i,
  input  rcit_pkg::scan_t scan_i,
  output rcit_pkg::scan_t scan_o
);
  import rcit_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [InoW-1:0] ino_q;
  scan_t           scan_q, scan_d;
  logic            live;
  logic            sel;

  assign live = (cnt_q != '0);
  assign sel  = (cmd_i.idx == MyIdx);

  // Search step: first live match, first free slot, addressed slot
  always_comb begin
    scan_d = scan_i;
    if (!scan_i.hit_fnd && live && (ino_q == scan_i.inode)) begin
      scan_d.hit_fnd = 1'b1;
      scan_d.hit_idx = MyIdx;
      scan_d.hit_cnt = cnt_q;
    end
    if (!scan_i.free_fnd && !live) begin
      scan_d.free_fnd = 1'b1;
      scan_d.free_idx = MyIdx;
    end
    if (IdxW'(scan_i.slot) == MyIdx) begin
      scan_d.put_cnt = cnt_q;
      scan_d.put_ino = ino_q;
    end
  end

  // Count update from the broadcast command
  always_comb begin
    cnt_d = cnt_q;
    priority if (cmd_i.kind == CMD_CLEAR) begin
      cnt_d = '0;
    end else if (sel) begin
      unique case (cmd_i.kind)
        CMD_INC:   cnt_d = (cnt_q == CountMax) ? CountMax : cnt_q + 1'b1;
        CMD_DEC:   cnt_d = cnt_q - 1'b1;
        CMD_CLAIM: cnt_d = CntW'(1);
        default:   cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      scan_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      scan_q <= scan_d;
    end
  end

  // Inode number, written on claim only
  always_ff @(posedge clk_i) begin
    if (sel && (cmd_i.kind == CMD_CLAIM)) begin
      ino_q <= cmd_i.inode;
    end
  end

  assign scan_o = scan_q;

endmodule

// File: rtl/rcit_div.sv
// Inode number split by inodes per disk block: reciprocal multiply, registered.
module rcit_div #(
  parameter int IPB = rcit_pkg::IpbDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rcit_pkg::InoW-1:0]    dividend_i,
  output logic                         done_o,
  output logic [rcit_pkg::InoW-1:0]    quot_o,
  output logic [$clog2(IPB+1)-1:0]     rem_o
);
  import rcit_pkg::*;

  localparam int RemW   = $clog2(IPB + 1);
  localparam int Shift  = InoW + $clog2(IPB);
  localparam int RecipW = InoW + 2;
  localparam int ProdW  = InoW + RecipW;
  // ceil(2^Shift / IPB): exact quotient for every InoW-bit dividend
  localparam logic [RecipW-1:0] Recip   = RecipW'(((1 << Shift) + IPB - 1) / IPB);
  localparam logic [InoW-1:0]   Divisor = InoW'(IPB);

  logic [InoW-1:0]  x_q;
  logic [InoW-1:0]  quot_q;
  logic [RemW-1:0]  rem_q;
  logic             x_vld_q;
  logic             quot_vld_q;
  logic             done_q;
  logic [ProdW-1:0] prod;
  logic [InoW-1:0]  back;

  // Quotient from the registered dividend, remainder from the quotient
  assign prod = ProdW'(x_q) * ProdW'(Recip);
  assign back = InoW'(quot_q * Divisor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q    <= 1'b0;
      quot_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      x_vld_q    <= start_i;
      quot_vld_q <= x_vld_q;
      done_q     <= quot_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
    end
    if (x_vld_q) begin
      quot_q <= InoW'(prod >> Shift);
    end
    if (quot_vld_q) begin
      rem_q <= RemW'(x_q - back);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/refcounted_inode_handle_table.sv
// Top level of the reference-counted inode handle table.
//
// Requests come in on a valid/ready handshake (in_valid_i, in_ready_o,
// in_data_i); one result beat leaves on out_valid_o/out_ready_i
// for every request beat. cfg_we_i/cfg_wdata_i set the first disk block of
// the inode table; write it only while the block is idle.
// Get and put send a search record down a chain of SLOTS cells, one cell per
// cycle; the finished record is decoded into the result register, then
// loaded into the output register. When a disk location is reported (miss
// loaded, released with write-back) the reciprocal-multiply divider fills it
// in first. Clear-all and the unused operation code skip the chain. One
// request is in flight at a time; the next request beat is taken in the cycle
// after the result is registered, even if the receiver has not taken it yet.
// A stalled receiver holds the result beat in the output register; a new
// result waits in the response state until the old one is taken.
// Reset zeroes every count and the search chain, restores the first block
// to 3 and drops out_valid_o; inode numbers are not cleared.
module refcounted_inode_handle_table #(
  parameter int SLOTS                 = rcit_pkg::SlotsDef,
  parameter int INODES_PER_DISK_BLOCK = rcit_pkg::IpbDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rcit_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rcit_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [rcit_pkg::BlkW-1:0]  cfg_wdata_i
);
  import rcit_pkg::*;

  localparam int RemW       = $clog2(INODES_PER_DISK_BLOCK + 1);
  localparam int InodeBytes = DiskBlockBytes / INODES_PER_DISK_BLOCK;

  fsm_e            state_q, state_d;
  in_t             req_q, req_d;
  out_t            res_q, res_d, res_scan;
  out_t            out_q;
  logic            out_valid_q;
  scan_t           link0_q, link0_d;
  cmd_t            cmd_q, cmd_d, cmd_scan;
  logic [BlkW-1:0] first_block_q;
  scan_t           lnk [SLOTS+1];
  scan_t           fin;
  logic            in_fire;
  logic            need_loc;
  logic            scan_done;
  logic            out_load;
  logic            div_start;
  logic            div_done;
  logic [InoW-1:0] div_quot;
  logic [RemW-1:0] div_rem;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin        = lnk[SLOTS];
  assign scan_done  = (state_q == S_SCAN) && fin.vld;
  assign div_start  = scan_done && need_loc;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // Chain of slot cells
  assign lnk[0] = link0_q;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rcit_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i  (cmd_q),
      .scan_i (lnk[g]),
      .scan_o (lnk[g+1])
    );
  end

  rcit_div #(
    .IPB(INODES_PER_DISK_BLOCK)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (res_scan.inode_of_slot),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Decode the finished search record
  always_comb begin
    res_scan = '0;
    cmd_scan = '0;
    need_loc = 1'b0;
    if (req_q.operation == OP_GET) begin
      if (fin.hit_fnd) begin
        res_scan.status        = STS_HIT;
        res_scan.slot_index    = SlotW'(fin.hit_idx);
        res_scan.references    = (fin.hit_cnt == CountMax) ? CountMax
                                                           : fin.hit_cnt + 1'b1;
        res_scan.inode_of_slot = req_q.inode_number;
        cmd_scan.kind          = CMD_INC;
        cmd_scan.idx           = fin.hit_idx;
      end else if (fin.free_fnd) begin
        res_scan.status        = STS_MISS;
        res_scan.slot_index    = SlotW'(fin.free_idx);
        res_scan.references    = CntW'(1);
        res_scan.inode_of_slot = req_q.inode_number;
        cmd_scan.kind          = CMD_CLAIM;
        cmd_scan.idx           = fin.free_idx;
        cmd_scan.inode         = req_q.inode_number;
        need_loc               = 1'b1;
      end else begin
        res_scan.status = STS_NOFREE;
      end
    end else begin
      // put: a slot beyond the table reads back a zero count
      res_scan.slot_index = req_q.slot;
      if (fin.put_cnt == '0) begin
        res_scan.status = STS_IGNORED;
      end else begin
        res_scan.references    = fin.put_cnt - 1'b1;
        res_scan.inode_of_slot = fin.put_ino;
        cmd_scan.kind          = CMD_DEC;
        cmd_scan.idx           = IdxW'(req_q.slot);
        if (fin.put_cnt == CntW'(1)) begin
          res_scan.status = STS_WRITEBACK;
          need_loc        = 1'b1;
        end else begin
          res_scan.status = STS_RELEASED;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_data_i.operation == OP_GET) || (in_data_i.operation == OP_PUT)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (fin.vld) begin
          state_d = need_loc ? S_DIV : S_RESP;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    req_d   = req_q;
    res_d   = res_q;
    link0_d = '0;
    cmd_d   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i;
          res_d = '0;
          unique case (in_data_i.operation)
            OP_GET, OP_PUT: begin
              link0_d.vld   = 1'b1;
              link0_d.inode = in_data_i.inode_number;
              link0_d.slot  = in_data_i.slot;
            end
            OP_CLEAR: begin
              cmd_d.kind   = CMD_CLEAR;
              res_d.status = STS_CLEARED;
            end
            default: res_d.status = STS_IGNORED;
          endcase
        end
      end
      S_SCAN: begin
        if (fin.vld) begin
          res_d = res_scan;
          cmd_d = cmd_scan;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d.disk_block  = BlkW'(div_quot) + first_block_q;
          res_d.byte_offset = OffW'(32'(div_rem) * InodeBytes);
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      link0_q       <= '0;
      cmd_q         <= '0;
      out_valid_q   <= 1'b0;
      first_block_q <= FirstBlockRst;
    end else begin
      state_q <= state_d;
      link0_q <= link0_d;
      cmd_q   <= cmd_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        first_block_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/rcit_checker.sv
// Port-level checks of the handle table, bound to the top level.
`include "refcounted_inode_handle_table_macros.svh"

module rcit_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rcit_pkg::out_t out_data_o
);
  import rcit_pkg::*;

  logic out_stall;
  logic no_loc_sts;
  logic no_ref_sts;
  logic loc_zero;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign no_loc_sts = (out_data_o.status == STS_HIT) || (out_data_o.status == STS_NOFREE) ||
                      (out_data_o.status == STS_IGNORED) ||
                      (out_data_o.status == STS_RELEASED) ||
                      (out_data_o.status == STS_CLEARED);
  assign no_ref_sts = (out_data_o.status == STS_NOFREE) || (out_data_o.status == STS_IGNORED) ||
                      (out_data_o.status == STS_CLEARED) ||
                      (out_data_o.status == STS_WRITEBACK);
  assign loc_zero   = (out_data_o.disk_block == '0) && (out_data_o.byte_offset == '0);

  // A stalled result beat holds
  `RCIT_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_data_o))

  // One request in flight: ready drops after each request beat
  `RCIT_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // Disk location only on miss loaded and write-back
  `RCIT_ASSERT(a_loc_only, clk_i, rst_ni, out_valid_o && no_loc_sts |-> loc_zero)

  // Statuses that leave no references behind
  `RCIT_ASSERT(a_zero_refs, clk_i, rst_ni, out_valid_o && no_ref_sts |-> out_data_o.references == '0)

  // Reset drops out_valid_o: no result beat once reset is sampled low
  `RCIT_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind refcounted_inode_handle_table rcit_checker u_rcit_checker (.*);

// File: tb/sv/refcounted_inode_handle_table_checker.sv
`timescale 1ns / 1ps
// Result predictor and in-order checker for the inode handle table testbench.
package handle_table_check_pkg;
  import rcit_pkg::*;

  // Operation code the block does not define; it must come back as ignored
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  class handle_table_checker;
    // Shadow copy of the table and of the first-block register
    logic [InoW-1:0] inode_tab [SlotsDef];
    logic [CntW-1:0] count_tab [SlotsDef];
    logic [BlkW-1:0] first_block;
    out_t            expected_replies [$];
    int unsigned     errors;
    int unsigned     replies_checked;

    function new();
      first_block = FirstBlockRst;
      errors = 0;
      replies_checked = 0;
      foreach (count_tab[i]) begin
        count_tab[i] = '0;
        inode_tab[i] = '0;
      end
    endfunction

    function void load_first_block(logic [BlkW-1:0] blk);
      first_block = blk;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // Disk block and byte offset of an inode record
    function void locate_inode(input logic [InoW-1:0] ino, output logic [BlkW-1:0] blk,
                               output logic [OffW-1:0] off);
      blk = BlkW'(ino / IpbDef) + first_block;
      off = OffW'((ino % IpbDef) * (DiskBlockBytes / IpbDef));
    endfunction

    // Apply one accepted request beat to the shadow table and queue its reply
    function void note_request(in_t req);
      out_t rsp;
      bit   done;
      rsp  = '0;
      done = 1'b0;
      case (req.operation)
        OP_GET: begin
          // live slot holding the inode, lowest index first
          for (int i = 0; i < SlotsDef && !done; i++) begin
            if (count_tab[i] != '0 && inode_tab[i] == req.inode_number) begin
              if (count_tab[i] != CountMax) count_tab[i]++;
              rsp.status        = STS_HIT;
              rsp.slot_index    = SlotW'(i);
              rsp.references    = count_tab[i];
              rsp.inode_of_slot = req.inode_number;
              done = 1'b1;
            end
          end
          // otherwise claim the lowest free slot
          for (int i = 0; i < SlotsDef && !done; i++) begin
            if (count_tab[i] == '0) begin
              count_tab[i]      = CntW'(1);
              inode_tab[i]      = req.inode_number;
              rsp.status        = STS_MISS;
              rsp.slot_index    = SlotW'(i);
              rsp.references    = CntW'(1);
              rsp.inode_of_slot = req.inode_number;
              locate_inode(req.inode_number, rsp.disk_block, rsp.byte_offset);
              done = 1'b1;
            end
          end
          if (!done) rsp.status = STS_NOFREE;
        end
        OP_PUT: begin
          rsp.slot_index = req.slot;
          if (count_tab[req.slot] == '0) begin
            rsp.status = STS_IGNORED;
          end else begin
            count_tab[req.slot]--;
            rsp.references    = count_tab[req.slot];
            rsp.inode_of_slot = inode_tab[req.slot];
            if (count_tab[req.slot] == '0) begin
              rsp.status = STS_WRITEBACK;
              locate_inode(inode_tab[req.slot], rsp.disk_block, rsp.byte_offset);
            end else begin
              rsp.status = STS_RELEASED;
            end
          end
        end
        OP_CLEAR: begin
          foreach (count_tab[i]) count_tab[i] = '0;
          rsp.status = STS_CLEARED;
        end
        default: begin
          rsp.status = STS_IGNORED;
        end
      endcase
      expected_replies.push_back(rsp);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: reply %0d %s expected %0d actual %0d",
                 $time, replies_checked, field, want, got);
      end
    endfunction

    // Compare one accepted result beat with the oldest expected reply
    function void check_response(out_t got);
      out_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected reply, status %0d slot %0d", $time, got.status,
                 got.slot_index);
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot_index", want.slot_index, got.slot_index);
      compare_field("references", want.references, got.references);
      compare_field("inode_of_slot", want.inode_of_slot, got.inode_of_slot);
      compare_field("disk_block", want.disk_block, got.disk_block);
      compare_field("byte_offset", want.byte_offset, got.byte_offset);
      replies_checked++;
    endfunction
  endclass

endpackage

// File: tb/sv/refcounted_inode_handle_table_test.sv
`timescale 1ns / 1ps
// Top-level testbench: drives request beats and checks every result beat in order.
module refcounted_inode_handle_table_test;
  import rcit_pkg::*;
  import handle_table_check_pkg::*;

  localparam int unsigned CycleLimit  = 1500000;
  localparam int unsigned PoolSize    = 96;
  localparam int unsigned FillGets    = 66;
  localparam int unsigned MixItems    = 210;
  localparam int unsigned Phases      = 7;
  localparam int unsigned QuietFrom   = 500;
  localparam int unsigned QuietTo     = 800;
  localparam int unsigned StallAfter  = 300;
  localparam int unsigned StallCycles = 400;
  localparam int unsigned DrainCycles = 100;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [BlkW-1:0]     cfg_wdata = '0;

  handle_table_checker sb = new();
  logic [InoW-1:0]     inode_pool [PoolSize];
  int unsigned         requests_sent = 0;
  int unsigned         cycle_count   = 0;

  refcounted_inode_handle_table i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_t make_req(logic [OpW-1:0] op, logic [InoW-1:0] ino,
                                   logic [SlotW-1:0] slot);
    in_t req;
    req.operation    = op;
    req.inode_number = ino;
    req.slot         = slot;
    return req;
  endfunction

  // Mostly gets on pooled inodes and puts, half on low slots; a little clear and noise
  function automatic in_t random_request(int unsigned get_pct, int unsigned put_pct);
    int unsigned roll;
    in_t         req;
    roll = $urandom_range(99);
    req  = make_req(OP_GET, InoW'($urandom), SlotW'($urandom));
    if (roll < get_pct) begin
      if ($urandom_range(9) != 0) req.inode_number = inode_pool[$urandom_range(PoolSize - 1)];
    end else if (roll < get_pct + put_pct) begin
      req.operation = OP_PUT;
      if ($urandom_range(1) != 0) req.slot = SlotW'($urandom_range(15));
    end else if (roll == 99) begin
      req.operation = OpUnused;
    end else begin
      req.operation = OP_CLEAR;
    end
    return req;
  endfunction

  // Offer one request beat; valid stays up until accepted
  task automatic send_request(input in_t req);
    if ((requests_sent < QuietFrom || requests_sent >= QuietTo) &&
        $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(90, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
  endtask

  // Register write once every reply is back
  task automatic write_first_block(input logic [BlkW-1:0] blk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= blk;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_first_block(blk);
  endtask

  // Receiver: random back-pressure, one long hold-off, one quiet stretch
  initial begin : reply_side
    int unsigned replies_seen;
    int unsigned hold_left;
    bit          held_once;
    replies_seen = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_response(out_data);
        replies_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held_once && replies_seen == StallAfter) begin
        held_once = 1'b1;
        hold_left = StallCycles;
        out_ready <= 1'b0;
      end else if (replies_seen >= QuietFrom && replies_seen < QuietTo) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // Stimulus
  initial begin : request_side
    logic [BlkW-1:0] blk;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hit, miss, release, write-back, ignored put, clear, unused code
    send_request(make_req(OP_GET, '0, '0));
    send_request(make_req(OP_GET, '1, '0));
    send_request(make_req(OP_GET, '1, '1));
    send_request(make_req(OP_PUT, '1, 6'd1));
    send_request(make_req(OP_PUT, '0, 6'd1));
    send_request(make_req(OP_PUT, '0, 6'd1));
    send_request(make_req(OP_PUT, '1, '1));
    send_request(make_req(OP_GET, '1, '0));
    send_request(make_req(OpUnused, '1, '1));
    send_request(make_req(OP_GET, 15'h2aaa, 6'h2a));
    send_request(make_req(OP_CLEAR, '1, '1));
    send_request(make_req(OP_PUT, '0, '0));
    send_request(make_req(OP_GET, 15'h2aaa, '0));
    send_request(make_req(OP_GET, 15'h5555, 6'h15));

    // random phases, each under a chosen first block (phases 0 and 6 use the reset value)
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       blk = FirstBlockRst;
        1:       blk = 16'd0;
        2:       blk = 16'd65023;
        3:       blk = 16'hffff;
        6:       blk = FirstBlockRst;
        default: blk = BlkW'($urandom_range(65023));
      endcase
      if (p != 0) write_first_block(blk);
      foreach (inode_pool[k]) inode_pool[k] = InoW'($urandom);
      // fill the table, then run past it into no-free
      for (int k = 0; k < FillGets; k++) begin
        send_request(make_req(OP_GET, inode_pool[k], SlotW'($urandom)));
      end
      // get-heavy half, then put-heavy half to drain counts
      for (int k = 0; k < MixItems; k++) begin
        if (k < MixItems / 2) send_request(random_request(60, 38));
        else send_request(random_request(30, 68));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: refcounted_inode_handle_table.f
+incdir+rtl
rtl/rcit_pkg.sv
rtl/rcit_cell.sv
rtl/rcit_div.sv
rtl/refcounted_inode_handle_table.sv
rtl/rcit_checker.sv
tb/sv/refcounted_inode_handle_table_checker.sv
tb/sv/refcounted_inode_handle_table_test.sv
